@@ design/pll_fraction_solver_unit_defines.svh @@
// assertion macros for the pll fraction solver
`ifndef PLL_FRACTION_SOLVER_UNIT_DEFINES_SVH
`define PLL_FRACTION_SOLVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define PFS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfs assertion failed");
// next-cycle implication, disabled in reset
`define PFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfs assertion failed");
`else
`define PFS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ design/pfs_pkg.sv @@
// types and constants of the pll fraction solver
package pfs_pkg;

    // field widths
    localparam int REF_W  = 20;
    localparam int PIX_W  = 20;
    localparam int VCO_W  = 28;
    localparam int PROD_W = 24;
    localparam int FRAC_W = 18;
    localparam int DIV_W  = PROD_W + FRAC_W;
    localparam int CNT_W  = 6;

    // accepted request ranges
    localparam logic [REF_W-1:0] REF_MIN_KHZ = 20'd5000;
    localparam logic [REF_W-1:0] REF_MAX_KHZ = 20'd750000;
    localparam logic [PIX_W-1:0] PIX_MIN_KHZ = 20'd782;
    localparam logic [PIX_W-1:0] PIX_MAX_KHZ = 20'd700000;

    // comparison limits; high limit of ref/n is tested as ref >= 50001*n
    localparam logic [VCO_W-1:0] CMP_LOW_K    = 28'd5000;
    localparam logic [VCO_W-1:0] CMP_HIGH_K1  = 28'd50001;
    localparam logic [VCO_W-1:0] VCO_LOW_K    = 28'd200000;
    localparam logic [VCO_W-1:0] VCO_HIGH_K   = 28'd700000;

    // divider limits
    localparam logic [3:0] N_START  = 4'd4;
    localparam logic [3:0] N_MIN    = 4'd1;
    localparam logic [3:0] N_MAX    = 4'd15;
    localparam logic [3:0] OD_START = 4'd2;
    localparam logic [3:0] OD_MAX   = 4'd8;

    localparam logic [REF_W-1:0] REF_RESET = 20'd33333;

    // sequencer states
    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_NDEC = 9'b000000010,
        ST_NINC = 9'b000000100,
        ST_ODUP = 9'b000001000,
        ST_ODDN = 9'b000010000,
        ST_MUL  = 9'b000100000,
        ST_DIV  = 9'b001000000,
        ST_PACK = 9'b010000000,
        ST_HOLD = 9'b100000000
    } pfs_state_t;

endpackage

@@ design/pll_fraction_solver_unit.sv @@
// pll fraction solver: divider search and restoring division under one sequencer
//
//  channel  | direction | contents
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata[19:0] pixel_khz
//  m_axis   | out       | tdata: pll_word, input_div, mult_int, mult_frac, out_div_log
//           |           | tuser: range_error
//  cfg      | in        | cfg_wdata[19:0] ref_clock_khz, written when cfg_wen
//
// a solvable request keeps s_axis_tready low through both divider searches, each
// step a down/up pair of states and each search closed by a pass that does not
// move, then the multiply, the one-bit restoring divider over all 42 quotient
// bits, pack and hold. an out-of-range request goes straight to pack and hold.
// aresetn clears the sequencer and output valid and sets ref_clock_khz to 33333.
// s_axis_tready is high only while the sequencer is idle; a result waiting in
// the output register stalls the next transaction once that one reaches hold.
`include "pll_fraction_solver_unit_defines.svh"

module pll_fraction_solver_unit
    import pfs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write
    input  logic        cfg_wen,
    input  logic [19:0] cfg_wdata,     // [19:0] ref_clock_khz
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [19:0] pixel_khz
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // [31:0] pll_word, [35:32] input_div,
                                       // [43:36] mult_int, [61:44] mult_frac,
                                       // [65:62] out_div_log
    output logic        m_axis_tuser   // [0] range_error
);

    pfs_state_t              state_reg, state_next;
    logic [REF_W-1:0]        ref_reg;
    logic [3:0]              n_reg, n_next;
    logic [3:0]              od_reg, od_next;
    logic [VCO_W-1:0]        vco_reg, vco_next;
    logic                    moved_reg, moved_next;
    logic                    err_reg, err_next;
    logic [DIV_W-1:0]        q_reg, q_next;
    logic [REF_W-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    m_valid_reg, m_valid_next;
    logic [71:0]             m_data_reg, m_data_next;
    logic                    m_user_reg, m_user_next;

    logic [PIX_W-1:0]        pix_in;
    logic                    in_bad;
    logic [VCO_W-1:0]        cmp_a, cmp_b;
    logic                    cmp_lt;
    logic [PROD_W-1:0]       prod;
    logic [REF_W:0]          trial;
    logic                    trial_ge;
    logic [31:0]             word;
    logic                    out_free;

    assign pix_in = s_axis_tdata[PIX_W-1:0];
    assign in_bad = (ref_reg < REF_MIN_KHZ) || (ref_reg > REF_MAX_KHZ) ||
                    (pix_in < PIX_MIN_KHZ) || (pix_in > PIX_MAX_KHZ);

    // shared less-than comparator for both divider searches
    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        case (state_reg)
            ST_NDEC: begin
                cmp_a = {{(VCO_W-REF_W){1'b0}}, ref_reg};
                cmp_b = VCO_W'({{(VCO_W-4){1'b0}}, n_reg} * CMP_LOW_K);
            end
            ST_NINC: begin
                cmp_a = {{(VCO_W-REF_W){1'b0}}, ref_reg};
                cmp_b = VCO_W'({{(VCO_W-4){1'b0}}, n_reg} * CMP_HIGH_K1);
            end
            ST_ODUP: begin
                cmp_a = vco_reg;
                cmp_b = VCO_LOW_K;
            end
            ST_ODDN: begin
                cmp_a = VCO_HIGH_K;
                cmp_b = vco_reg;
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end
    assign cmp_lt = cmp_a < cmp_b;

    // vco times n, fits 24 bits once the search is done
    assign prod = PROD_W'(vco_reg[PIX_W-1:0] * {{(PIX_W-4){1'b0}}, n_reg});

    // one restoring division step
    assign trial    = {rem_reg, q_reg[DIV_W-1]};
    assign trial_ge = trial >= {1'b0, ref_reg};

    // packed word, summed and wrapped as the fields overlap
    assign word = {q_reg[FRAC_W-1:0], 14'b0}
                + {16'b0, od_reg, 12'b0}
                + {20'b0, n_reg, 8'b0}
                + {8'b0, q_reg[DIV_W-1:FRAC_W]};

    assign out_free = !m_valid_reg || m_axis_tready;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        od_next      = od_reg;
        vco_next     = vco_reg;
        moved_next   = moved_reg;
        err_next     = err_reg;
        q_next       = q_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_next     = N_START;
                    od_next    = OD_START;
                    vco_next   = {{(VCO_W-PIX_W-2){1'b0}}, pix_in, 2'b0};
                    err_next   = in_bad;
                    state_next = in_bad ? ST_PACK : ST_NDEC;
                end
            end
            ST_NDEC: begin
                moved_next = cmp_lt && (n_reg > N_MIN);
                if (moved_next) begin
                    n_next = n_reg - 4'd1;
                end
                state_next = ST_NINC;
            end
            ST_NINC: begin
                if (!cmp_lt && (n_reg < N_MAX)) begin
                    n_next     = n_reg + 4'd1;
                    state_next = ST_NDEC;
                end else begin
                    state_next = moved_reg ? ST_NDEC : ST_ODUP;
                end
            end
            ST_ODUP: begin
                moved_next = cmp_lt && (od_reg < OD_MAX);
                if (moved_next) begin
                    od_next  = od_reg + 4'd1;
                    vco_next = {vco_reg[VCO_W-2:0], 1'b0};
                end
                state_next = ST_ODDN;
            end
            ST_ODDN: begin
                if (cmp_lt && (od_reg > 4'd0)) begin
                    od_next    = od_reg - 4'd1;
                    vco_next   = {1'b0, vco_reg[VCO_W-1:1]};
                    state_next = ST_ODUP;
                end else begin
                    state_next = moved_reg ? ST_ODUP : ST_MUL;
                end
            end
            ST_MUL: begin
                q_next     = {prod, {FRAC_W{1'b0}}};
                rem_next   = '0;
                cnt_next   = CNT_W'(DIV_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (trial_ge) begin
                    rem_next = REF_W'(trial - {1'b0, ref_reg});
                end else begin
                    rem_next = trial[REF_W-1:0];
                end
                q_next = {q_reg[DIV_W-2:0], trial_ge};
                if (cnt_reg == '0) begin
                    state_next = ST_PACK;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_PACK: begin
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_user_next  = err_reg;
                    if (err_reg) begin
                        m_data_next = '0;
                    end else begin
                        m_data_next = {6'b0, od_reg, q_reg[FRAC_W-1:0],
                                       q_reg[FRAC_W+7:FRAC_W], n_reg, word};
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            ref_reg     <= REF_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wen) begin
                ref_reg <= cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        od_reg     <= od_next;
        vco_reg    <= vco_next;
        moved_reg  <= moved_next;
        err_reg    <= err_next;
        q_reg      <= q_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // a range error carries an all-zero payload
    `PFS_ASSERT_SAME(a_err_zero, aclk, aresetn,
        m_axis_tvalid && m_axis_tuser, m_axis_tdata == 72'd0)
    // a solved result has n in 1..15 and od at most 8
    `PFS_ASSERT_SAME(a_res_range, aclk, aresetn,
        m_axis_tvalid && !m_axis_tuser,
        (m_axis_tdata[35:32] != 4'd0) && (m_axis_tdata[65:62] <= OD_MAX))
    // the output divider search ends inside the vco window, with n nonzero
    `PFS_ASSERT_SAME(a_vco_win, aclk, aresetn,
        state_reg == ST_MUL,
        (vco_reg >= VCO_LOW_K) && (vco_reg <= VCO_HIGH_K) && (n_reg != 4'd0))
    // an accepted transaction leaves idle
    `PFS_ASSERT_NEXT(a_accept_busy, aclk, aresetn,
        s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

@@ tb/sv/pll_fraction_solver_unit_test.sv @@
// testbench for the pll fraction solver: predicted settings checked against the result stream
module pll_fraction_solver_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pfs_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 120;
    localparam int REPORT_LIMIT    = 10;

    // search windows and fraction scale
    localparam logic [63:0] CMP_LOW_KHZ  = 64'd5000;
    localparam logic [63:0] CMP_HIGH_KHZ = 64'd50000;
    localparam logic [63:0] VCO_LOW_KHZ  = 64'd200000;
    localparam logic [63:0] VCO_HIGH_KHZ = 64'd700000;
    localparam logic [63:0] FRAC_ONE     = 64'd262144;

    typedef struct packed {
        logic [31:0] word;
        logic [3:0]  n_div;
        logic [7:0]  m_int;
        logic [17:0] frac;
        logic [3:0]  od_log;
        logic        range_err;
    } pll_setting_t;

    // expected pll settings, predicted at request acceptance
    class setting_ledger;
        pll_setting_t expected_q[$];
        logic [19:0]  ref_khz;
        int           mismatches;

        function new();
            ref_khz    = REF_RESET;
            mismatches = 0;
        endfunction

        function void set_reference(logic [19:0] khz);
            ref_khz = khz;
        endfunction

        function pll_setting_t solve_setting(logic [19:0] pixel_khz);
            pll_setting_t s;
            logic [63:0]  refk, pix, n, od, prod, frac, mult;
            int           guard;
            bit           moved;
            s    = '0;
            refk = {44'd0, ref_khz};
            pix  = {44'd0, pixel_khz};
            if (refk < REF_MIN_KHZ || refk > REF_MAX_KHZ ||
                pix < PIX_MIN_KHZ || pix > PIX_MAX_KHZ) begin
                s.range_err = 1'b1;
                return s;
            end
            // input divider: comparison clock into 5000..50000
            n     = 64'd4;
            moved = 1'b1;
            guard = 0;
            while (moved && guard < 32) begin
                moved = 1'b0;
                if (refk / n < CMP_LOW_KHZ && n > 64'd1) begin
                    n     = n - 64'd1;
                    moved = 1'b1;
                end
                if (refk / n > CMP_HIGH_KHZ && n < 64'd15) begin
                    n     = n + 64'd1;
                    moved = 1'b1;
                end
                guard++;
            end
            // output divider: pixel times divider into 200000..700000
            od    = 64'd2;
            moved = 1'b1;
            guard = 0;
            while (moved && guard < 32) begin
                moved = 1'b0;
                if ((pix << od) < VCO_LOW_KHZ && od < 64'd8) begin
                    od    = od + 64'd1;
                    moved = 1'b1;
                end
                if ((pix << od) > VCO_HIGH_KHZ && od > 64'd0) begin
                    od    = od - 64'd1;
                    moved = 1'b1;
                end
                guard++;
            end
            prod        = (pix << od) * n;
            frac        = ((prod * FRAC_ONE) / refk) % FRAC_ONE;
            mult        = prod / refk;
            prod        = (frac << 14) + (od << 12) + (n << 8) + mult;
            s.word      = prod[31:0];
            s.n_div     = n[3:0];
            s.m_int     = mult[7:0];
            s.frac      = frac[17:0];
            s.od_log    = od[3:0];
            return s;
        endfunction

        function void note_request(logic [19:0] pixel_khz);
            expected_q.push_back(solve_setting(pixel_khz));
        endfunction

        function void compare_field(string field, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch on %s: expected %h, got %h (ref %0d kHz)",
                             field, exp_v, got_v, ref_khz);
            end
        endfunction

        function void check_result(logic [71:0] data, logic flag);
            pll_setting_t exp_s;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result transaction with nothing expected: %h / %b", data, flag);
                return;
            end
            exp_s = expected_q.pop_front();
            compare_field("pll_word",    exp_s.word,             data[31:0]);
            compare_field("input_div",   {28'd0, exp_s.n_div},   {28'd0, data[35:32]});
            compare_field("mult_int",    {24'd0, exp_s.m_int},   {24'd0, data[43:36]});
            compare_field("mult_frac",   {14'd0, exp_s.frac},    {14'd0, data[61:44]});
            compare_field("out_div_log", {28'd0, exp_s.od_log},  {28'd0, data[65:62]});
            compare_field("range_error", {31'd0, exp_s.range_err}, {31'd0, flag});
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wen       = 1'b0;
    logic [19:0] cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;    // [19:0] pixel_khz
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;          // [31:0] word, [35:32] n, [43:36] m,
                                        // [61:44] frac, [65:62] od
    logic        m_axis_tuser;          // [0] range_error

    setting_ledger ledger;
    bit            hold_request = 1'b0;
    bit            tx_burst     = 1'b0;

    pll_fraction_solver_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always begin
        aclk = 1'b0;
        #HALF_PERIOD;
        aclk = 1'b1;
        #HALF_PERIOD;
    end

    // result receiver: random stalls, stall-free stretches and one long hold-off
    initial begin
        int stall_left;
        int mode_left;
        int rx_mode;
        stall_left = 0;
        mode_left  = 0;
        rx_mode    = 0;
        forever begin
            @(negedge aclk);
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_mode != 0 && $urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 19) == 0)
                    stall_left = $urandom_range(20, 80);
                else
                    stall_left = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            ledger.check_result(m_axis_tdata, m_axis_tuser);
    end

    // watchdog on cycles without any transaction
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function int sender_gap();
        int unsigned roll;
        if ($urandom_range(0, 39) == 0)
            tx_burst = !tx_burst;
        if (tx_burst)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    // mostly solvable requests, with boundary neighbors and raw 20-bit values
    function logic [19:0] random_pixel();
        int unsigned roll;
        int          base;
        int          shift;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 20'($urandom_range(782, 700000));
        if (roll < 65)
            return 20'($urandom_range(782, 25000));
        if (roll < 82) begin
            shift = $urandom_range(0, 9);
            base  = ($urandom_range(0, 1) == 1) ? (700000 >> shift) : (200000 >> shift);
            return 20'(base + $urandom_range(0, 4) - 2);
        end
        if (roll < 88) begin
            case ($urandom_range(0, 3))
                0:       return 20'd781;
                1:       return 20'd782;
                2:       return 20'd700000;
                default: return 20'd700001;
            endcase
        end
        return 20'($urandom());
    endfunction

    // one request transaction; valid stays up across back-to-back requests
    task automatic send_pixel(logic [19:0] pixel_khz);
        int gap;
        gap = sender_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata  <= {4'd0, pixel_khz};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        ledger.note_request(pixel_khz);
    endtask

    // stop sending and wait for every expected result
    task automatic drain(int settle);
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (ledger.pending() > 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reference(logic [19:0] khz);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= khz;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        ledger.set_reference(khz);
    endtask

    initial begin
        logic [19:0] edge_pixels[$];
        logic [19:0] ref_plan[$];
        int          count;
        ledger = new();
        // pixel extremes, range edges and divider boundaries at the reset reference
        edge_pixels = '{20'd0, 20'd1, 20'd781, 20'd782, 20'd783, 20'd25000, 20'd99999,
                        20'd100000, 20'd148500, 20'd199999, 20'd200000, 20'd350000,
                        20'd350001, 20'd524288, 20'd699999, 20'd700000, 20'd700001,
                        20'hFFFFF, 20'd65000, 20'd108000, 20'h55555, 20'hAAAAA};
        // reference extremes, out-of-range references and divider search edges
        ref_plan = '{20'd5000, 20'd750000, 20'd4999, 20'd750001, 20'd0, 20'hFFFFF,
                     20'd19999, 20'd20000, 20'd200000, 20'd200004, 20'd14999, 20'd27000,
                     20'($urandom_range(5000, 750000)), 20'($urandom_range(5000, 750000)),
                     REF_RESET};

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (edge_pixels[i])
            send_pixel(edge_pixels[i]);

        foreach (ref_plan[p]) begin
            drain(SETTLE_CYCLES);
            write_reference(ref_plan[p]);
            if (ref_plan[p] < REF_MIN_KHZ || ref_plan[p] > REF_MAX_KHZ)
                count = 40;
            else
                count = 90;
            for (int k = 0; k < count; k++) begin
                // receiver holds off while requests keep coming
                if (p == 1 && k == 30)
                    hold_request = 1'b1;
                send_pixel(random_pixel());
            end
        end

        drain(TAIL_CYCLES);
        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
